@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for clocked checks with async reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a holds -> c holds in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");

// a holds -> c holds in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");

`endif

@@ hdl/pcf_pkg.sv @@
// ----------------------------------------------------------------------------
// pcf_pkg
// Types, constants and CRC-32 helpers for the PNG chunk framer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pcf_pkg;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

	// byte sequencer steps: 0-3 length, 4-7 type (7 also data), 8-11 CRC
	localparam logic [3:0] STEP_FIRST    = 4'd0;
	localparam logic [3:0] STEP_TYPE0    = 4'd4;
	localparam logic [3:0] STEP_BODY_END = 4'd7;
	localparam logic [3:0] STEP_CRC0     = 4'd8;
	localparam logic [3:0] STEP_CRC_END  = 4'd11;

	typedef enum logic [1:0] {
		KIND_BEGIN = 2'd0,
		KIND_DATA  = 2'd1,
		KIND_ERR   = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic        close;
		logic [31:0] chunk_type;
		logic [30:0] chunk_length;
		logic [7:0]  data_byte;
	} cmd_entry_t;

	function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
		end
		return c;
	endfunction

	// big-endian byte pick, index 0 is the most significant byte
	function automatic logic [7:0] word_byte(input logic [31:0] w, input logic [1:0] idx);
		logic [7:0] r;
		unique case (idx)
			2'd0: r = w[31:24];
			2'd1: r = w[23:16];
			2'd2: r = w[15:8];
			2'd3: r = w[7:0];
			default: r = 8'd0;
		endcase
		return r;
	endfunction

endpackage

@@ hdl/pcf_ifs.sv @@
// ----------------------------------------------------------------------------
// pcf_ifs
// Valid/ready channels of the PNG chunk framer: command in, byte stream out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pcf_cmd_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [31:0] chunk_type;
	logic [30:0] chunk_length;
	logic [7:0]  data_byte;

	modport source (output valid, action, chunk_type, chunk_length, data_byte, input ready);
	modport sink   (input valid, action, chunk_type, chunk_length, data_byte, output ready);
endinterface

interface pcf_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       chunk_done;
	logic       error;

	modport source (output valid, out_byte, run_last, chunk_done, error, input ready);
	modport sink   (input valid, out_byte, run_last, chunk_done, error, output ready);
endinterface

@@ hdl/pcf_front.sv @@
// ----------------------------------------------------------------------------
// pcf_front
// Accepts command items, tracks the open chunk and its byte count, and
// classifies each item as begin, data or error for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcf_front
	import pcf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	pcf_cmd_if.sink    cmd,
	output logic       push_valid,
	output cmd_entry_t push_entry,
	input  logic       push_ready
);

	logic        chunk_open_q;
	logic [30:0] bytes_left_q;
	logic [30:0] left_dec;
	logic        accept;
	logic        is_err;

	assign cmd.ready  = push_ready;
	assign accept     = cmd.valid & push_ready;
	assign push_valid = cmd.valid;
	assign left_dec   = bytes_left_q - 31'd1;
	assign is_err     = cmd.action ? !chunk_open_q : chunk_open_q;

	always_comb begin
		push_entry.chunk_type   = cmd.chunk_type;
		push_entry.chunk_length = cmd.chunk_length;
		push_entry.data_byte    = cmd.data_byte;
		if (is_err) begin
			push_entry.kind  = KIND_ERR;
			push_entry.close = 1'b0;
		end else if (!cmd.action) begin
			push_entry.kind  = KIND_BEGIN;
			push_entry.close = (cmd.chunk_length == 31'd0);
		end else begin
			push_entry.kind  = KIND_DATA;
			push_entry.close = (left_dec == 31'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_open_q <= 1'b0;
			bytes_left_q <= 31'd0;
		end else if (accept && !is_err) begin
			chunk_open_q <= !push_entry.close;
			bytes_left_q <= cmd.action ? left_dec : cmd.chunk_length;
		end
	end

endmodule

@@ hdl/pcf_queue.sv @@
// ----------------------------------------------------------------------------
// pcf_queue
// Small register FIFO of classified items between front and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcf_queue
	import pcf_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push_valid,
	input  cmd_entry_t push_entry,
	output logic       push_ready,
	output logic       head_valid,
	output cmd_entry_t head_entry,
	input  logic       pop
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	cmd_entry_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_FULL);
	assign head_valid = (count_q != '0);
	assign head_entry = mem_q[rd_ptr_q];
	assign do_push    = push_valid & push_ready;
	assign do_pop     = pop & head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

@@ hdl/pcf_back.sv @@
// ----------------------------------------------------------------------------
// pcf_back
// Byte sequencer: walks the queue head through its length, type, data and
// CRC bytes, folds the CRC, and drives the registered output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcf_back
	import pcf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  cmd_entry_t head_entry,
	output logic       pop,
	pcf_byte_if.source stream
);

	logic        active_q;
	logic [3:0]  step_q;
	logic [31:0] crc_q;
	logic        o_valid_q;
	logic [7:0]  o_byte_q;
	logic        o_last_q;
	logic        o_done_q;
	logic        o_err_q;

	logic [3:0]  cur_step;
	logic        emit;
	logic        is_last;
	logic        is_err;
	logic        in_body;
	logic [7:0]  cur_byte;
	logic [31:0] crc_base;

	assign is_err   = (head_entry.kind == KIND_ERR);
	assign cur_step = active_q ? step_q :
		((head_entry.kind == KIND_BEGIN) ? STEP_FIRST : STEP_BODY_END);
	assign emit     = head_valid && (!o_valid_q || stream.ready);
	assign is_last  = (cur_step == STEP_CRC_END) ||
		((cur_step == STEP_BODY_END) && !head_entry.close);
	assign in_body  = (cur_step >= STEP_TYPE0) && (cur_step < STEP_CRC0);
	assign pop      = emit && is_last;
	assign crc_base = (cur_step == STEP_TYPE0) ? CRC_INIT : crc_q;

	always_comb begin
		if (is_err) begin
			cur_byte = 8'd0;
		end else if (cur_step < STEP_TYPE0) begin
			cur_byte = word_byte({1'b0, head_entry.chunk_length}, cur_step[1:0]);
		end else if (in_body) begin
			cur_byte = (head_entry.kind == KIND_DATA) ? head_entry.data_byte :
				word_byte(head_entry.chunk_type, cur_step[1:0]);
		end else begin
			cur_byte = word_byte(~crc_q, cur_step[1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			step_q    <= STEP_FIRST;
			crc_q     <= CRC_INIT;
			o_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				o_valid_q <= 1'b1;
				active_q  <= !is_last;
				step_q    <= cur_step + 4'd1;
				if (in_body && !is_err) begin
					crc_q <= crc_fold(crc_base, cur_byte);
				end
			end else if (stream.ready) begin
				o_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			o_byte_q <= cur_byte;
			o_last_q <= is_last;
			o_done_q <= (cur_step == STEP_CRC_END);
			o_err_q  <= is_err;
		end
	end

	assign stream.valid      = o_valid_q;
	assign stream.out_byte   = o_byte_q;
	assign stream.run_last   = o_last_q;
	assign stream.chunk_done = o_done_q;
	assign stream.error      = o_err_q;

endmodule

@@ hdl/png_chunk_framer_crc32.sv @@
// ----------------------------------------------------------------------------
// png_chunk_framer_crc32
// PNG chunk framer: length, type, data and CRC-32 bytes from begin/data items.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload                                         Item
// cmd      in   action, chunk_type, chunk_length, data_byte     one command
// stream   out  out_byte, run_last, chunk_done, error           one byte
//
// Input side takes one item per cycle while the queue (QUEUE_DEPTH entries)
// has room. Output side gives one byte per cycle unless the stream stalls:
// a begin yields 8 bytes (12 for an empty chunk), a data item 1 (5 when it
// closes the chunk), an error 1. The byte sequencer sets the rate. Reset
// clears the queue, chunk state and output valid. Either side may stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module png_chunk_framer_crc32
	import pcf_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	pcf_cmd_if.sink    cmd,
	pcf_byte_if.source stream
);

	logic       push_valid;
	logic       push_ready;
	cmd_entry_t push_entry;
	logic       head_valid;
	cmd_entry_t head_entry;
	logic       pop;

	pcf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.push_ready (push_ready)
	);

	pcf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.push_ready (push_ready),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop)
	);

	pcf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop),
		.stream     (stream)
	);

endmodule

@@ hdl/pcf_checker.sv @@
// ----------------------------------------------------------------------------
// pcf_checker
// Port-level checks on the framer's byte stream, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module pcf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       run_last,
	input logic       chunk_done,
	input logic       error
);

	`ASSERT_NEXT(a_hold_stalled, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(run_last) && $stable(chunk_done) && $stable(error))

	`ASSERT_IMPLIES(a_err_shape, clk, arst_n, out_valid && error, run_last && (out_byte == 8'd0) && !chunk_done)

	`ASSERT_IMPLIES(a_done_ends_item, clk, arst_n, out_valid && chunk_done, run_last && !error)

endmodule

bind png_chunk_framer_crc32 pcf_checker u_pcf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (stream.valid),
	.out_ready  (stream.ready),
	.out_byte   (stream.out_byte),
	.run_last   (stream.run_last),
	.chunk_done (stream.chunk_done),
	.error      (stream.error)
);
